[rtl/core/jsf_pkg.sv]
`default_nettype none

package jsf_pkg;

  localparam int LIM_W  = 14;
  localparam int POS_W  = 15;
  localparam int NORM_W = 16;
  localparam int JOY_W  = 16;
  localparam int MAG_W  = 15;
  localparam int FRAC_W = 14;
  localparam int PROD_W = MAG_W + LIM_W;
  localparam int QUO_W  = MAG_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  localparam logic [MAG_W-1:0]         MAX_LIMIT_STEPS = 15'd16383;
  localparam logic [LIM_W-1:0]         LIM_RESET       = 14'd1024;
  localparam logic signed [NORM_W-1:0] Q_ONE           = 16'sd16384;
  localparam logic signed [NORM_W-1:0] DEADZONE_CODES  = 16'sd819;
  localparam logic [PROD_W-1:0]        ROUND_HALF      = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [CNT_W-1:0]         DIV_STEPS       = CNT_W'(QUO_W);

  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [LIM_W-1:0]         lim_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef enum logic [2:0] {
    ACT_SET_TARGET = 3'd0,
    ACT_TICK       = 3'd1,
    ACT_STOP       = 3'd2,
    ACT_CENTER     = 3'd3,
    ACT_REAPPLY    = 3'd4
  } action_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic norm_t shape_joy(input logic signed [JOY_W-1:0] v);
    norm_t c;
    c = v;
    if (v > Q_ONE) begin
      c = Q_ONE;
    end else if (v < -Q_ONE) begin
      c = -Q_ONE;
    end
    if (c <= DEADZONE_CODES && c >= -DEADZONE_CODES) begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/two_axis_joystick_step_follower.sv]
// Two-axis joystick step follower: rotation and tilt axes chase step targets.
// Input channel in_valid/in_stall carries one action beat with in_action,
// in_joy_x and in_joy_y; each beat returns exactly one result beat on
// out_valid/out_stall with the step flags, positions, normalized values
// and the moving flag after the action.
// cfg_we/cfg_index/cfg_wdata write the two travel limits; write only while idle.
// Tick, center and unknown actions go straight to the final state;
// set_target and reapply_limits compute both targets on one shared 15x14
// multiplier, one axis at a time; stop may run a serial restoring divider
// with a 15-bit quotient for each axis, axes in turn.
// One action is in flight at a time: in_stall is high from acceptance until
// the result is loaded into the output register. A result held by out_stall
// does not block the next input beat; the following result waits in the
// final sequencer state until the output register frees.
// Reset clears positions, targets and normalized values, sets both limits
// to 1024 and empties the output register.
`default_nettype none

module two_axis_joystick_step_follower (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_action,
  input  wire logic signed [15:0]  in_joy_x,
  input  wire logic signed [15:0]  in_joy_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_rot_step,
  output logic                     out_rot_dir_up,
  output logic                     out_tilt_step,
  output logic                     out_tilt_dir_up,
  output logic signed [14:0]       out_rot_pos_out,
  output logic signed [14:0]       out_tilt_pos_out,
  output logic signed [15:0]       out_norm_x_out,
  output logic signed [15:0]       out_norm_y_out,
  output logic                     out_moving,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [13:0]         cfg_wdata
);
  import jsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MULW,
    S_NORM,
    S_DIVW,
    S_DONE
  } state_t;

  localparam logic [0:0] CFG_ROT_LIMIT  = 1'b0;
  localparam logic [0:0] CFG_TILT_LIMIT = 1'b1;

  state_t    state_r;
  logic      ax_r;
  lim_t      rot_lim_r;
  lim_t      tilt_lim_r;
  pos_t      rot_pos_r;
  pos_t      tilt_pos_r;
  pos_t      rot_tgt_r;
  pos_t      tilt_tgt_r;
  norm_t     norm_x_r;
  norm_t     norm_y_r;
  logic      rs_r;
  logic      ru_r;
  logic      ts_r;
  logic      tu_r;
  logic      out_valid_r;
  logic      out_rs_r;
  logic      out_ru_r;
  logic      out_ts_r;
  logic      out_tu_r;
  pos_t      out_rot_pos_r;
  pos_t      out_tilt_pos_r;
  norm_t     out_norm_x_r;
  norm_t     out_norm_y_r;
  logic      out_moving_r;

  logic      acc;
  lim_t      rl;
  lim_t      tl;
  lim_t      cur_lim;
  norm_t     cur_norm;
  norm_t     neg_norm;
  pos_t      cur_pos;
  pos_t      neg_pos;
  mag_t      norm_mag;
  mag_t      pos_mag;
  mag_t      mul_steps;
  pos_t      tgt_new;
  logic      lim_zero;
  logic      div_start;
  mag_t      div_quo;
  div_stat_t div_stat;
  norm_t     norm_new_mag;
  norm_t     norm_new;
  logic      rot_go;
  logic      rot_up;
  logic      tilt_go;
  logic      tilt_up;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign rl = ({1'b0, rot_lim_r} > MAX_LIMIT_STEPS) ? MAX_LIMIT_STEPS[LIM_W-1:0] : rot_lim_r;
  assign tl = ({1'b0, tilt_lim_r} > MAX_LIMIT_STEPS) ? MAX_LIMIT_STEPS[LIM_W-1:0] : tilt_lim_r;

  assign cur_lim  = ax_r ? tl : rl;
  assign cur_norm = ax_r ? norm_y_r : norm_x_r;
  assign cur_pos  = ax_r ? tilt_pos_r : rot_pos_r;
  assign neg_norm = -cur_norm;
  assign neg_pos  = -cur_pos;
  assign norm_mag = cur_norm[NORM_W-1] ? neg_norm[MAG_W-1:0] : cur_norm[MAG_W-1:0];
  assign pos_mag  = cur_pos[POS_W-1] ? neg_pos : cur_pos;
  assign lim_zero = (cur_lim == '0);

  assign tgt_new  = cur_norm[NORM_W-1] ? -pos_t'(mul_steps) : pos_t'(mul_steps);

  assign div_start = (state_r == S_NORM) && !lim_zero && (pos_mag < {1'b0, cur_lim});

  always_comb begin
    if (state_r == S_DIVW) begin
      norm_new_mag = {1'b0, div_quo};
    end else if (lim_zero) begin
      norm_new_mag = '0;
    end else begin
      norm_new_mag = Q_ONE;
    end
    norm_new = cur_pos[POS_W-1] ? -norm_new_mag : norm_new_mag;
  end

  assign rot_go  = (rot_pos_r != rot_tgt_r);
  assign rot_up  = (rot_tgt_r > rot_pos_r);
  assign tilt_go = (tilt_pos_r != tilt_tgt_r);
  assign tilt_up = (tilt_tgt_r > tilt_pos_r);

  jsf_mul u_mul (
    .clk   (clk),
    .load  (state_r == S_MUL),
    .mag   (norm_mag),
    .lim   (cur_lim),
    .steps (mul_steps)
  );

  jsf_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (pos_mag),
    .num_lo ({1'b0, cur_lim}),
    .den    ({cur_lim, 1'b0}),
    .quo    (div_quo),
    .stat   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ax_r           <= 1'b0;
      rot_lim_r      <= LIM_RESET;
      tilt_lim_r     <= LIM_RESET;
      rot_pos_r      <= '0;
      tilt_pos_r     <= '0;
      rot_tgt_r      <= '0;
      tilt_tgt_r     <= '0;
      norm_x_r       <= '0;
      norm_y_r       <= '0;
      rs_r           <= 1'b0;
      ru_r           <= 1'b0;
      ts_r           <= 1'b0;
      tu_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      out_rs_r       <= 1'b0;
      out_ru_r       <= 1'b0;
      out_ts_r       <= 1'b0;
      out_tu_r       <= 1'b0;
      out_rot_pos_r  <= '0;
      out_tilt_pos_r <= '0;
      out_norm_x_r   <= '0;
      out_norm_y_r   <= '0;
      out_moving_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROT_LIMIT:  rot_lim_r  <= cfg_wdata;
          CFG_TILT_LIMIT: tilt_lim_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            rs_r <= (in_action == ACT_TICK) && rot_go;
            ru_r <= (in_action == ACT_TICK) && rot_go && rot_up;
            ts_r <= (in_action == ACT_TICK) && tilt_go;
            tu_r <= (in_action == ACT_TICK) && tilt_go && tilt_up;
            ax_r <= 1'b0;
            unique case (action_t'(in_action))
              ACT_SET_TARGET: begin
                norm_x_r <= shape_joy(in_joy_x);
                norm_y_r <= shape_joy(in_joy_y);
                state_r  <= S_MUL;
              end
              ACT_TICK: begin
                if (rot_go) begin
                  rot_pos_r <= rot_up ? rot_pos_r + pos_t'(1) : rot_pos_r - pos_t'(1);
                end
                if (tilt_go) begin
                  tilt_pos_r <= tilt_up ? tilt_pos_r + pos_t'(1) : tilt_pos_r - pos_t'(1);
                end
                state_r <= S_DONE;
              end
              ACT_STOP: begin
                rot_tgt_r  <= rot_pos_r;
                tilt_tgt_r <= tilt_pos_r;
                state_r    <= S_NORM;
              end
              ACT_CENTER: begin
                rot_pos_r  <= '0;
                tilt_pos_r <= '0;
                rot_tgt_r  <= '0;
                tilt_tgt_r <= '0;
                norm_x_r   <= '0;
                norm_y_r   <= '0;
                state_r    <= S_DONE;
              end
              ACT_REAPPLY: begin
                state_r <= S_MUL;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end

        S_MUL: begin
          state_r <= S_MULW;
        end

        S_MULW: begin
          if (ax_r) begin
            tilt_tgt_r <= tgt_new;
            state_r    <= S_DONE;
          end else begin
            rot_tgt_r <= tgt_new;
            ax_r      <= 1'b1;
            state_r   <= S_MUL;
          end
        end

        S_NORM: begin
          if (div_start) begin
            state_r <= S_DIVW;
          end else begin
            if (ax_r) begin
              norm_y_r <= norm_new;
              state_r  <= S_DONE;
            end else begin
              norm_x_r <= norm_new;
              ax_r     <= 1'b1;
            end
          end
        end

        S_DIVW: begin
          if (div_stat.done) begin
            if (ax_r) begin
              norm_y_r <= norm_new;
              state_r  <= S_DONE;
            end else begin
              norm_x_r <= norm_new;
              ax_r     <= 1'b1;
              state_r  <= S_NORM;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_rs_r       <= rs_r;
            out_ru_r       <= ru_r;
            out_ts_r       <= ts_r;
            out_tu_r       <= tu_r;
            out_rot_pos_r  <= rot_pos_r;
            out_tilt_pos_r <= tilt_pos_r;
            out_norm_x_r   <= norm_x_r;
            out_norm_y_r   <= norm_y_r;
            out_moving_r   <= rot_go || tilt_go;
            state_r        <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rot_step     = out_rs_r;
  assign out_rot_dir_up   = out_ru_r;
  assign out_tilt_step    = out_ts_r;
  assign out_tilt_dir_up  = out_tu_r;
  assign out_rot_pos_out  = out_rot_pos_r;
  assign out_tilt_pos_out = out_tilt_pos_r;
  assign out_norm_x_out   = out_norm_x_r;
  assign out_norm_y_out   = out_norm_y_r;
  assign out_moving       = out_moving_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("accepted beat did not make the block busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside the final state");

  a_rot_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (rot_pos_r != $past(rot_pos_r))) |->
      (rot_pos_r == pos_t'(0) || rot_pos_r == $past(rot_pos_r) + pos_t'(1) ||
       rot_pos_r == $past(rot_pos_r) - pos_t'(1)))
    else $error("rotation position jumped by more than one step");

endmodule

`default_nettype wire

[rtl/core/jsf_mul.sv]
`default_nettype none

module jsf_mul (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire jsf_pkg::mag_t mag,
  input  wire jsf_pkg::lim_t lim,
  output jsf_pkg::mag_t      steps
);
  import jsf_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] rounded;
  mag_t              raw;
  mag_t              lim_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(mag) * PROD_W'(lim);
    end
  end

  assign rounded = prod_r + ROUND_HALF;
  assign raw     = rounded[PROD_W-1:FRAC_W];
  assign lim_ext = {1'b0, lim};
  assign steps   = (raw > lim_ext) ? lim_ext : raw;

endmodule

`default_nettype wire

[rtl/core/jsf_div.sv]
`default_nettype none

module jsf_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire jsf_pkg::mag_t num_hi,
  input  wire jsf_pkg::mag_t num_lo,
  input  wire jsf_pkg::mag_t den,
  output jsf_pkg::mag_t      quo,
  output jsf_pkg::div_stat_t stat
);
  import jsf_pkg::*;

  mag_t             rem_r;
  mag_t             quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      quo_r <= num_lo;
    end else if (busy_r) begin
      rem_r <= fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[tb/sv/tb_two_axis_joystick_step_follower.sv]
module tb_two_axis_joystick_step_follower;
  import jsf_pkg::*;

  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam logic [0:0] REG_ROT_LIMIT = 1'b0;
  localparam logic [0:0] REG_TILT_LIMIT = 1'b1;
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 178;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic rot_step;
    logic rot_dir_up;
    logic tilt_step;
    logic tilt_dir_up;
    logic signed [14:0] rot_pos;
    logic signed [14:0] tilt_pos;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic moving;
  } follow_res_t;

  typedef struct packed {
    logic [2:0] act;
    logic signed [15:0] jx;
    logic signed [15:0] jy;
    logic typed;
    follow_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = ACT_TICK;
  logic signed [15:0] in_joy_x = '0;
  logic signed [15:0] in_joy_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_rot_step;
  logic out_rot_dir_up;
  logic out_tilt_step;
  logic out_tilt_dir_up;
  logic signed [14:0] out_rot_pos_out;
  logic signed [14:0] out_tilt_pos_out;
  logic signed [15:0] out_norm_x_out;
  logic signed [15:0] out_norm_y_out;
  logic out_moving;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_ROT_LIMIT;
  logic [13:0] cfg_wdata = '0;

  two_axis_joystick_step_follower i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_joy_x(in_joy_x), .in_joy_y(in_joy_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rot_step(out_rot_step), .out_rot_dir_up(out_rot_dir_up),
    .out_tilt_step(out_tilt_step), .out_tilt_dir_up(out_tilt_dir_up),
    .out_rot_pos_out(out_rot_pos_out), .out_tilt_pos_out(out_tilt_pos_out),
    .out_norm_x_out(out_norm_x_out), .out_norm_y_out(out_norm_y_out),
    .out_moving(out_moving),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // follower state
  int rot_pos, tilt_pos, rot_tgt, tilt_tgt, nx, ny;
  int rot_lim = int'(LIM_RESET);
  int tilt_lim = int'(LIM_RESET);

  follow_res_t follow_q[$];
  int items_sent = 0;
  int burst_left = 0;
  int mismatches = 0;
  int cycles = 0;
  int stall_run = 0;
  int stall_mode = 0;
  follow_res_t seen;
  follow_res_t want;

  function automatic int clamp_deadzone(logic signed [15:0] v);
    int c;
    c = int'(v);
    if (c > Q_ONE) c = Q_ONE;
    if (c < -Q_ONE) c = -Q_ONE;
    if (c <= DEADZONE_CODES && c >= -DEADZONE_CODES) c = 0;
    return c;
  endfunction

  function automatic int norm_to_steps(int n, int lim);
    longint m, r;
    m = longint'((n < 0) ? -n : n);
    r = (m * lim + 8192) >>> 14;
    if (r > lim) r = lim;
    return (n < 0) ? int'(-r) : int'(r);
  endfunction

  function automatic int pos_to_norm(int p, int lim);
    longint m, r;
    if (lim <= 0) return 0;
    m = longint'((p < 0) ? -p : p);
    r = (m * 2 * 16384 + lim) / (2 * longint'(lim));
    if (r > 16384) r = 16384;
    return (p < 0) ? int'(-r) : int'(r);
  endfunction

  function automatic follow_res_t follow_predict(logic [2:0] act, logic signed [15:0] jx,
                                                 logic signed [15:0] jy);
    follow_res_t r;
    r = '0;
    case (act)
      ACT_SET_TARGET: begin
        nx = clamp_deadzone(jx);
        ny = clamp_deadzone(jy);
        rot_tgt = norm_to_steps(nx, rot_lim);
        tilt_tgt = norm_to_steps(ny, tilt_lim);
      end
      ACT_TICK: begin
        if (rot_pos != rot_tgt) begin
          r.rot_step = 1'b1;
          r.rot_dir_up = rot_tgt > rot_pos;
          rot_pos += r.rot_dir_up ? 1 : -1;
        end
        if (tilt_pos != tilt_tgt) begin
          r.tilt_step = 1'b1;
          r.tilt_dir_up = tilt_tgt > tilt_pos;
          tilt_pos += r.tilt_dir_up ? 1 : -1;
        end
      end
      ACT_STOP: begin
        rot_tgt = rot_pos;
        tilt_tgt = tilt_pos;
        nx = pos_to_norm(rot_pos, rot_lim);
        ny = pos_to_norm(tilt_pos, tilt_lim);
      end
      ACT_CENTER: begin
        rot_pos = 0;
        tilt_pos = 0;
        rot_tgt = 0;
        tilt_tgt = 0;
        nx = 0;
        ny = 0;
      end
      ACT_REAPPLY: begin
        rot_tgt = norm_to_steps(nx, rot_lim);
        tilt_tgt = norm_to_steps(ny, tilt_lim);
      end
      default: ;
    endcase
    r.rot_pos = rot_pos[14:0];
    r.tilt_pos = tilt_pos[14:0];
    r.norm_x = nx[15:0];
    r.norm_y = ny[15:0];
    r.moving = (rot_pos != rot_tgt) || (tilt_pos != tilt_tgt);
    return r;
  endfunction

  function automatic logic signed [15:0] pick_joy();
    int k, m;
    logic signed [15:0] v;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 5))
        0: v = 16'sh7fff;
        1: v = 16'sh8000;
        2: v = 16'sd16384;
        3: v = -16'sd16384;
        4: v = 16'sd16385;
        default: v = -16'sd16385;
      endcase
    end else if (k <= 2) begin
      m = $urandom_range(812, 830);
      v = 16'($urandom_range(0, 1) ? m : -m);
    end else if (k <= 5) begin
      v = 16'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  // hold off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (follow_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_beat(input logic [2:0] act, input logic signed [15:0] jx,
                           input logic signed [15:0] jy, input logic use_typed,
                           input follow_res_t typed_res);
    follow_res_t pred;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    if ($urandom_range(0, 199) == 0) begin
      drain_results();
    end else if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_joy_x <= jx;
    in_joy_y <= jy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = follow_predict(act, jx, jy);
    follow_q.push_back(use_typed ? typed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_limits(input lim_t r, input lim_t t);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROT_LIMIT;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_index <= REG_TILT_LIMIT;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    rot_lim = int'(r);
    tilt_lim = int'(t);
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(8, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_run[0];
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_rot_step, out_rot_dir_up, out_tilt_step, out_tilt_dir_up, out_rot_pos_out,
              out_tilt_pos_out, out_norm_x_out, out_norm_y_out, out_moving};
      if (follow_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat at cycle %0d", cycles);
        mismatches++;
      end else begin
        want = follow_q.pop_front();
        if (seen !== want) begin
          if (mismatches < 10) begin
            $display("mismatch cycle %0d: exp st %b%b%b%b pos %0d %0d norm %0d %0d mv %b",
                     cycles, want.rot_step, want.rot_dir_up, want.tilt_step, want.tilt_dir_up,
                     want.rot_pos, want.tilt_pos, want.norm_x, want.norm_y, want.moving);
            $display("  got st %b%b%b%b pos %0d %0d norm %0d %0d mv %b",
                     seen.rot_step, seen.rot_dir_up, seen.tilt_step, seen.tilt_dir_up,
                     seen.rot_pos, seen.tilt_pos, seen.norm_x, seen.norm_y, seen.moving);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tbl [N_DIRECTED];
    lim_t plan_r [N_PHASES];
    lim_t plan_t [N_PHASES];
    int k, run;

    dir_tbl = '{
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ACT_RSVD5, -16'sd1, -16'sd1, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ACT_SET_TARGET, 16'sh7fff, 16'sh8000, 1'b1, '{0, 0, 0, 0, 0, 0, 16384, -16384, 1}},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b1, '{1, 1, 1, 0, 1, -1, 16384, -16384, 1}},
      '{ACT_TICK, -16'sd1, 16'sd0, 1'b1, '{1, 1, 1, 0, 2, -2, 16384, -16384, 1}},
      '{ACT_STOP, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 2, -2, 32, -32, 0}},
      '{ACT_SET_TARGET, 16'sd819, -16'sd819, 1'b1, '{0, 0, 0, 0, 2, -2, 0, 0, 1}},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b1, '{1, 0, 1, 1, 1, -1, 0, 0, 1}},
      '{ACT_SET_TARGET, 16'sd820, -16'sd820, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b0, '0},
      '{ACT_RSVD6, 16'sh5555, 16'shaaaa, 1'b0, '0},
      '{ACT_RSVD7, 16'shaaaa, 16'sh5555, 1'b0, '0},
      '{ACT_REAPPLY, 16'sd0, 16'sd0, 1'b0, '0},
      '{ACT_CENTER, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ACT_SET_TARGET, 16'sd824, -16'sd824, 1'b0, '0},
      '{ACT_SET_TARGET, 16'sd16384, 16'sd16384, 1'b1, '{0, 0, 0, 0, 0, 0, 16384, 16384, 1}},
      '{ACT_SET_TARGET, -16'sd16385, 16'sd16385, 1'b1,
        '{0, 0, 0, 0, 0, 0, -16384, 16384, 1}},
      '{ACT_STOP, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{ACT_SET_TARGET, 16'sh8000, 16'sd0, 1'b0, '0},
      '{ACT_TICK, 16'shffff, 16'shffff, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b0, '0},
      '{ACT_TICK, 16'sd0, 16'sd0, 1'b0, '0},
      '{ACT_REAPPLY, 16'sd0, 16'sd0, 1'b0, '0}
    };
    plan_r = '{14'd16383, 14'd0, 14'd1, 14'd16383, lim_t'($urandom), 14'd1024,
               lim_t'($urandom_range(2, 64)), 14'd0};
    plan_t = '{14'd16383, 14'd0, 14'd16383, 14'd0, lim_t'($urandom), 14'd1,
               lim_t'($urandom_range(2, 64)), 14'd16383};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_beat(dir_tbl[i].act, dir_tbl[i].jx, dir_tbl[i].jy, dir_tbl[i].typed,
                dir_tbl[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_limits(plan_r[ph], plan_t[ph]);
      while (items_sent < N_DIRECTED + (ph + 1) * ITEMS_PER_PHASE) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          send_beat(ACT_SET_TARGET, pick_joy(), pick_joy(), 1'b0, '0);
          run = $urandom_range(1, 24);
          repeat (run) send_beat(ACT_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else if (k < 67) begin
          send_beat(ACT_STOP, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else if (k < 75) begin
          send_beat(ACT_REAPPLY, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else if (k < 79) begin
          send_beat(ACT_CENTER, 16'($urandom), 16'($urandom), 1'b0, '0);
        end else if (k < 84) begin
          send_beat(3'($urandom_range(ACT_RSVD5, ACT_RSVD7)), 16'($urandom), 16'($urandom),
                    1'b0, '0);
        end else begin
          send_beat(ACT_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
